@@ sv/day_of_week_last_weekday_assert.svh @@
// Assertion macros for the day_of_week_last_weekday block.
`ifndef DAY_OF_WEEK_LAST_WEEKDAY_ASSERT_SVH
`define DAY_OF_WEEK_LAST_WEEKDAY_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define DOWL_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define DOWL_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DOWL_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg)
`define DOWL_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg)
`endif
`endif

@@ sv/dowl_pkg.sv @@
// Shared types, constants and calendar tables of the weekday pipeline.
package dowl_pkg;

  // Division of the year by 100 as a multiply by a scaled reciprocal.
  localparam int unsigned YEAR_W      = 14;
  localparam int unsigned RECIP_W     = 13;
  localparam int unsigned PROD_W      = YEAR_W + RECIP_W;
  localparam int unsigned DIV100_SH   = 19;
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

  // Month numbers and limits that the control logic names.
  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;
  localparam logic [2:0] WDAY_MAX  = 3'd6;

  // One input item.
  typedef struct packed {
    logic [4:0]        day;
    logic [3:0]        month;
    logic [YEAR_W-1:0] year;
    logic [2:0]        target_weekday;
  } in_t;

  // One result item.
  typedef struct packed {
    logic [2:0] day_of_week;
    logic [4:0] last_weekday_day;
    logic       invalid_input;
  } out_t;

  // After the first stage: the year quotient by 100 and the range checks.
  typedef struct packed {
    logic [4:0]        day;
    logic [3:0]        month;
    logic [YEAR_W-1:0] year;
    logic [2:0]        target;
    logic [7:0]        cent_q;
    logic              fld_ok;
  } s1_t;

  // After the second stage: month keys, month length and the year term mod 7.
  typedef struct packed {
    logic [4:0] day;
    logic [4:0] len;
    logic [2:0] mkey;
    logic [2:0] ykey;
    logic [2:0] target;
    logic       bad;
  } s2_t;

  // After the third stage: weekday of the date and of the last day of month.
  typedef struct packed {
    logic [2:0] dow;
    logic [2:0] dow_last;
    logic [4:0] len;
    logic [2:0] target;
    logic       bad;
  } s3_t;

  // Remainder by 7 of an 8-bit value, folding 3-bit digits since 8 = 1 mod 7.
  function automatic logic [2:0] mod7(input logic [7:0] x);
    logic [4:0] f1;
    logic [3:0] f2;
    f1 = {3'b0, x[7:6]} + {2'b0, x[5:3]} + {2'b0, x[2:0]};
    f2 = {2'b0, f1[4:3]} + {1'b0, f1[2:0]};
    return (f2 >= 4'd7) ? f2[2:0] - 3'd7 : f2[2:0];
  endfunction

  // Month key of a common year.
  function automatic logic [2:0] month_key(input logic [3:0] m);
    logic [2:0] k;
    case (m)
      4'd1:    k = 3'd0;
      4'd2:    k = 3'd3;
      4'd3:    k = 3'd3;
      4'd4:    k = 3'd6;
      4'd5:    k = 3'd1;
      4'd6:    k = 3'd4;
      4'd7:    k = 3'd6;
      4'd8:    k = 3'd2;
      4'd9:    k = 3'd5;
      4'd10:   k = 3'd0;
      4'd11:   k = 3'd3;
      4'd12:   k = 3'd5;
      default: k = 3'd0;
    endcase
    return k;
  endfunction

  // Length of a month of a common year.
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] n;
    case (m)
      4'd2:                      n = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
      default:                   n = 5'd31;
    endcase
    return n;
  endfunction

  // Century key, indexed by (year / 100 + 1) mod 4 (centuries 19, 20, 21, 22).
  function automatic logic [2:0] cent_key(input logic [1:0] c);
    logic [2:0] k;
    case (c)
      2'd0:    k = 3'd1;
      2'd1:    k = 3'd0;
      2'd2:    k = 3'd5;
      default: k = 3'd3;
    endcase
    return k;
  endfunction

endpackage

@@ sv/dowl_div.sv @@
// First stage: year divided by 100 through a reciprocal multiply, range checks.
module dowl_div (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  dowl_pkg::in_t up_data,
  output logic          dn_valid,
  input  logic          dn_ready,
  output dowl_pkg::s1_t dn_data
);
  import dowl_pkg::*;

  logic              valid_r;
  logic              valid_nxt;
  s1_t               data_r;
  s1_t               data_nxt;
  logic [PROD_W-1:0] prod;

  // The stage takes an item when it is empty or its item moves on.
  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    valid_nxt = up_ready ? up_valid : valid_r;
  end

  // The quotient is exact for every 14-bit year.
  always_comb begin
    prod            = PROD_W'(up_data.year) * PROD_W'(RECIP_100);
    data_nxt.day    = up_data.day;
    data_nxt.month  = up_data.month;
    data_nxt.year   = up_data.year;
    data_nxt.target = up_data.target_weekday;
    data_nxt.cent_q = prod[DIV100_SH +: 8];
    data_nxt.fld_ok = (up_data.month != 4'd0) && (up_data.month <= MONTH_DEC) &&
                      (up_data.target_weekday <= WDAY_MAX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;
endmodule

@@ sv/dowl_key.sv @@
// Second stage: year remainder, leap rule, keys, month length and day check.
module dowl_key (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  dowl_pkg::s1_t up_data,
  output logic          dn_valid,
  input  logic          dn_ready,
  output dowl_pkg::s2_t dn_data
);
  import dowl_pkg::*;

  logic              valid_r;
  logic              valid_nxt;
  s2_t               data_r;
  s2_t               data_nxt;
  logic [YEAR_W-1:0] rem_full;
  logic [6:0]        yy;
  logic              leap;
  logic [1:0]        cidx;
  logic [7:0]        ysum;
  logic [4:0]        len;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    valid_nxt = up_ready ? up_valid : valid_r;
  end

  always_comb begin
    // Remainder by 100 as year - 64q - 32q - 4q.
    rem_full = up_data.year - {up_data.cent_q, 6'b0}
                            - {1'b0, up_data.cent_q, 5'b0}
                            - {4'b0, up_data.cent_q, 2'b0};
    yy       = rem_full[6:0];
    // Divisible by 400 means remainder 0 and quotient a multiple of 4.
    leap     = ((up_data.year[1:0] == 2'd0) && (yy != 7'd0)) ||
               ((yy == 7'd0) && (up_data.cent_q[1:0] == 2'd0));
    // Folding into 1900..2299 picks the century key by the quotient mod 4.
    cidx     = up_data.cent_q[1:0] + 2'd1;
    ysum     = {1'b0, yy} + {3'b0, yy[6:2]} + {5'b0, cent_key(cidx)};

    len = month_len(up_data.month);
    if (leap && (up_data.month == MONTH_FEB)) begin
      len = 5'd29;
    end

    data_nxt.day    = up_data.day;
    data_nxt.len    = len;
    data_nxt.ykey   = mod7(ysum);
    data_nxt.target = up_data.target;
    data_nxt.bad    = !up_data.fld_ok || (up_data.day == 5'd0) || (up_data.day > len);
    if (leap && (up_data.month == MONTH_JAN)) begin
      data_nxt.mkey = 3'd6;
    end else if (leap && (up_data.month == MONTH_FEB)) begin
      data_nxt.mkey = 3'd2;
    end else begin
      data_nxt.mkey = month_key(up_data.month);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;
endmodule

@@ sv/dowl_wday.sv @@
// Third stage: weekday of the date and of the month's last day, both mod 7.
module dowl_wday (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  dowl_pkg::s2_t up_data,
  output logic          dn_valid,
  input  logic          dn_ready,
  output dowl_pkg::s3_t dn_data
);
  import dowl_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  s3_t        data_r;
  s3_t        data_nxt;
  logic [7:0] sum_day;
  logic [7:0] sum_last;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    valid_nxt = up_ready ? up_valid : valid_r;
  end

  // Two key sums: one for the queried day, one for the month's last day.
  always_comb begin
    sum_day           = {3'b0, up_data.day} + {5'b0, up_data.mkey} + {5'b0, up_data.ykey};
    sum_last          = {3'b0, up_data.len} + {5'b0, up_data.mkey} + {5'b0, up_data.ykey};
    data_nxt.dow      = mod7(sum_day);
    data_nxt.dow_last = mod7(sum_last);
    data_nxt.len      = up_data.len;
    data_nxt.target   = up_data.target;
    data_nxt.bad      = up_data.bad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;
endmodule

@@ sv/dowl_out.sv @@
// Output stage: last target weekday of the month and the result register.
module dowl_out (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  dowl_pkg::s3_t  up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output dowl_pkg::out_t dn_data
);
  import dowl_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  out_t       data_r;
  out_t       data_nxt;
  logic [3:0] back;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    valid_nxt = up_ready ? up_valid : valid_r;
  end

  // Step back from the last day by the weekday distance to the target.
  always_comb begin
    back = {1'b0, up_data.dow_last} + 4'd7 - {1'b0, up_data.target};
    if (back >= 4'd7) begin
      back = back - 4'd7;
    end
    if (up_data.bad) begin
      data_nxt.day_of_week      = 3'd0;
      data_nxt.last_weekday_day = 5'd0;
      data_nxt.invalid_input    = 1'b1;
    end else begin
      data_nxt.day_of_week      = up_data.dow;
      data_nxt.last_weekday_day = up_data.len - {2'b0, back[2:0]};
      data_nxt.invalid_input    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;
endmodule

@@ sv/day_of_week_last_weekday.sv @@
// Top level of the Gregorian weekday and last-weekday-of-month pipeline.
//
// Input channel in_valid/in_stall/in_data carries a date and a target weekday;
// an item is taken at a rising edge with in_valid high and in_stall low.
// Result channel out_valid/out_stall/out_data carries the weekday of the date,
// the day number of the last target weekday in that month and an invalid flag.
// Weekday codes run 0 Saturday, 1 Sunday, up to 6 Friday.
// An item passes four registered stages in order: the reciprocal multiply
// for year / 100, the key and month-length lookup, the two mod-7 sums and
// the result register.
// One item per cycle while out_stall is low; every stage holds a valid bit.
// A stalled receiver holds the result register; stages behind it keep filling
// until all four are full, and only then is in_stall raised.
// Synchronous reset clears all valid bits; the data registers are not reset.
// Bad month, day or target weekday gives zeros with invalid_input set.
`include "day_of_week_last_weekday_assert.svh"
module day_of_week_last_weekday (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  dowl_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output dowl_pkg::out_t out_data
);
  import dowl_pkg::*;

  logic s1_ready;
  logic s1_valid;
  s1_t  s1_data;
  logic s2_ready;
  logic s2_valid;
  s2_t  s2_data;
  logic s3_ready;
  logic s3_valid;
  s3_t  s3_data;
  logic s4_ready;

  // Year quotient and range checks.
  dowl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (s1_ready),
    .up_data  (in_data),
    .dn_valid (s1_valid),
    .dn_ready (s2_ready),
    .dn_data  (s1_data)
  );

  // Calendar keys and month length.
  dowl_key u_key (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s2_ready),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_ready (s3_ready),
    .dn_data  (s2_data)
  );

  // Weekday sums.
  dowl_wday u_wday (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s3_ready),
    .up_data  (s2_data),
    .dn_valid (s3_valid),
    .dn_ready (s4_ready),
    .dn_data  (s3_data)
  );

  // Result register.
  dowl_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s3_valid),
    .up_ready (s4_ready),
    .up_data  (s3_data),
    .dn_valid (out_valid),
    .dn_ready (!out_stall),
    .dn_data  (out_data)
  );

  assign in_stall = !s1_ready;

  // The input can only back up when the whole pipeline is full and held.
  `DOWL_ASSERT_NOW(a_stall_full, clk, rst_n, in_stall, out_valid && out_stall && s1_valid && s2_valid && s3_valid, "input stalled while the pipeline has room")
  // A valid result names a last weekday in the final week of the month.
  `DOWL_ASSERT_NOW(a_last_range, clk, rst_n, out_valid && !out_data.invalid_input, (out_data.last_weekday_day >= 5'd22) && (out_data.last_weekday_day <= 5'd31) && (out_data.day_of_week <= WDAY_MAX), "result out of range")
  // A flagged result carries zero fields.
  `DOWL_ASSERT_NOW(a_bad_zero, clk, rst_n, out_valid && out_data.invalid_input, (out_data.day_of_week == 3'd0) && (out_data.last_weekday_day == 5'd0), "flagged result has nonzero fields")
  // A full last stage with a free output moves its item out on the next edge.
  `DOWL_ASSERT_NEXT(a_drain, clk, rst_n, s3_valid && !out_stall, out_valid, "item lost between last stage and output")
endmodule
